// ===== hw/rtl/lphs_pkg.sv =====
// Shared types, codes and sizes for the linear probing hash set.
package lphs_pkg;

    localparam int TABLE_SLOTS_DEF = 1024;
    localparam int KEY_W = 32;
    localparam int MODE_W = 2;
    localparam int STATUS_W = 3;
    localparam int SLOT_W = 10;
    localparam int TAG_W = 2;
    localparam int WORD_W = KEY_W + TAG_W;
    localparam int DIGIT_W = 4;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

    // result codes
    localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_DELETED   = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd5;

    // slot tags
    localparam logic [TAG_W-1:0] TAG_EMPTY   = 2'd0;
    localparam logic [TAG_W-1:0] TAG_USED    = 2'd1;
    localparam logic [TAG_W-1:0] TAG_DELETED = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_DONE
    } state_t;

endpackage

// ===== hw/rtl/lphs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module lphs_ram #(
    parameter int WIDTH = lphs_pkg::WORD_W,
    parameter int DEPTH = lphs_pkg::TABLE_SLOTS_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/lphs_hash.sv =====
// Home slot unit: key modulo table size, a mask or a digit-serial remainder.
module lphs_hash #(
    parameter int TABLE_SLOTS = lphs_pkg::TABLE_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [lphs_pkg::KEY_W-1:0]     key,
    output logic                           done,
    output logic [$clog2(TABLE_SLOTS)-1:0] home
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam bit POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
    localparam int STEPS = lphs_pkg::KEY_W / lphs_pkg::DIGIT_W;
    localparam int CNT_W = $clog2(STEPS);
    localparam logic [IDX_W:0] MODN = (IDX_W + 1)'(TABLE_SLOTS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [lphs_pkg::KEY_W-1:0]  sh_reg, sh_next;
    logic [IDX_W-1:0]            rem_reg, rem_next;
    logic [IDX_W-1:0]            rem_step;
    logic [IDX_W:0]              trial;

    // four restoring remainder steps, one key bit each, MSB first
    always_comb
    begin
        rem_step = rem_reg;
        trial = '0;
        for (int i = 0; i < lphs_pkg::DIGIT_W; i++)
        begin
            trial = {rem_step, sh_reg[lphs_pkg::KEY_W-1-i]};
            if (trial >= MODN)
            begin
                trial = trial - MODN;
            end
            rem_step = trial[IDX_W-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next = cnt_reg;
        sh_next = sh_reg;
        rem_next = rem_reg;
        if (start)
        begin
            cnt_next = '0;
            sh_next = key;
            if (POW2)
            begin
                rem_next = key[IDX_W-1:0];
                done_next = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                rem_next = '0;
                done_next = 1'b0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = rem_step;
            sh_next = sh_reg << lphs_pkg::DIGIT_W;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign home = rem_reg;

endmodule

// ===== hw/rtl/linear_probe_hash_set_unit.sv =====
// Top level: linear probing hash set with one slot RAM and a probe sequencer.
//
//  channel | direction | payload          | handshake
//  req     | in        | mode, key        | req_valid / req_stall
//  rsp     | out       | status, slot     | rsp_valid / rsp_stall
//
// One transaction at a time; a request probes 1 to TABLE_SLOTS slots. The probe
// loop reads one slot of the RAM per cycle; when TABLE_SLOTS is not a power of
// two, the remainder unit takes four key bits per cycle. After reset a clearing
// pass marks every slot empty, with req_stall high. A stalled response sits in
// the output register; the next request is taken meanwhile.
module linear_probe_hash_set_unit #(
    parameter int TABLE_SLOTS = lphs_pkg::TABLE_SLOTS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  lphs_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output lphs_pkg::rsp_t rsp
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int PAD_W = (IDX_W > lphs_pkg::SLOT_W) ? IDX_W : lphs_pkg::SLOT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

    lphs_pkg::state_t state_reg, state_next;

    logic [IDX_W-1:0]                cur_reg, cur_next;
    logic [IDX_W-1:0]                count_reg, count_next;
    logic [IDX_W-1:0]                clr_reg, clr_next;
    logic                            free_valid_reg, free_valid_next;
    logic [IDX_W-1:0]                free_reg, free_next;
    logic [lphs_pkg::MODE_W-1:0]     mode_reg, mode_next;
    logic [lphs_pkg::KEY_W-1:0]      key_reg, key_next;
    lphs_pkg::rsp_t                  res_reg, res_next;
    logic                            out_valid_reg, out_valid_next;
    lphs_pkg::rsp_t                  out_reg, out_next;

    logic                            hash_start;
    logic                            hash_done;
    logic [IDX_W-1:0]                hash_home;

    logic                            wr_en;
    logic [IDX_W-1:0]                wr_addr;
    logic [lphs_pkg::WORD_W-1:0]     wr_data;
    logic                            rd_en;
    logic [IDX_W-1:0]                rd_addr;
    logic [lphs_pkg::WORD_W-1:0]     rd_data;

    logic [lphs_pkg::TAG_W-1:0]      rd_tag;
    logic [lphs_pkg::KEY_W-1:0]      rd_key;
    logic                            is_empty;
    logic                            is_used;
    logic                            is_match;
    logic                            have_free;
    logic [IDX_W-1:0]                free_sel;
    logic [IDX_W-1:0]                cur_wrap;
    logic                            stop;
    logic [IDX_W-1:0]                res_idx;
    logic [PAD_W-1:0]                res_wide;

    lphs_hash #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (req.key),
        .done  (hash_done),
        .home  (hash_home)
    );

    lphs_ram #(
        .WIDTH(lphs_pkg::WORD_W),
        .DEPTH(TABLE_SLOTS)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_tag = rd_data[lphs_pkg::TAG_W-1:0];
    assign rd_key = rd_data[lphs_pkg::WORD_W-1:lphs_pkg::TAG_W];
    assign is_empty = (rd_tag == lphs_pkg::TAG_EMPTY);
    assign is_used = (rd_tag == lphs_pkg::TAG_USED);
    assign is_match = is_used && (rd_key == key_reg);
    // anything not occupied (empty or deleted) may take an insert
    assign have_free = free_valid_reg || !is_used;
    assign free_sel = free_valid_reg ? free_reg : cur_reg;
    assign cur_wrap = (cur_reg == LAST_IDX) ? '0 : cur_reg + 1'b1;
    assign stop = is_empty || is_match || (count_reg == LAST_IDX);

    assign req_stall = (state_reg != lphs_pkg::ST_IDLE);
    assign hash_start = (state_reg == lphs_pkg::ST_IDLE) && req_valid;

    always_comb
    begin
        state_next = state_reg;
        cur_next = cur_reg;
        count_next = count_reg;
        clr_next = clr_reg;
        free_valid_next = free_valid_reg;
        free_next = free_reg;
        mode_next = mode_reg;
        key_next = key_reg;
        res_next = res_reg;
        out_valid_next = out_valid_reg;
        out_next = out_reg;
        wr_en = 1'b0;
        wr_addr = cur_reg;
        wr_data = {key_reg, lphs_pkg::TAG_USED};
        rd_en = 1'b0;
        rd_addr = cur_wrap;
        res_idx = cur_reg;
        res_wide = '0;

        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            lphs_pkg::ST_CLEAR:
            begin
                wr_en = 1'b1;
                wr_addr = clr_reg;
                wr_data = {{lphs_pkg::KEY_W{1'b0}}, lphs_pkg::TAG_EMPTY};
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_IDX)
                begin
                    state_next = lphs_pkg::ST_IDLE;
                end
            end
            lphs_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    mode_next = req.mode;
                    key_next = req.key;
                    state_next = lphs_pkg::ST_HASH;
                end
            end
            lphs_pkg::ST_HASH:
            begin
                if (hash_done)
                begin
                    rd_en = 1'b1;
                    rd_addr = hash_home;
                    cur_next = hash_home;
                    count_next = '0;
                    free_valid_next = 1'b0;
                    state_next = lphs_pkg::ST_PROBE;
                end
            end
            lphs_pkg::ST_PROBE:
            begin
                if (!stop)
                begin
                    // fetch the next slot while this one is checked
                    rd_en = 1'b1;
                    rd_addr = cur_wrap;
                    cur_next = cur_wrap;
                    count_next = count_reg + 1'b1;
                    if (!is_used && !free_valid_reg)
                    begin
                        free_valid_next = 1'b1;
                        free_next = cur_reg;
                    end
                end
                else
                begin
                    state_next = lphs_pkg::ST_DONE;
                    res_next.status = lphs_pkg::STAT_NOT_FOUND;
                    res_idx = cur_reg;
                    unique case (mode_reg)
                        lphs_pkg::MODE_INSERT:
                        begin
                            if (is_match)
                            begin
                                res_next.status = lphs_pkg::STAT_DUPLICATE;
                            end
                            else if (have_free)
                            begin
                                wr_en = 1'b1;
                                wr_addr = free_sel;
                                wr_data = {key_reg, lphs_pkg::TAG_USED};
                                res_next.status = lphs_pkg::STAT_INSERTED;
                                res_idx = free_sel;
                            end
                            else
                            begin
                                res_next.status = lphs_pkg::STAT_FULL;
                            end
                        end
                        lphs_pkg::MODE_DELETE:
                        begin
                            if (is_match)
                            begin
                                wr_en = 1'b1;
                                wr_addr = cur_reg;
                                wr_data = {key_reg, lphs_pkg::TAG_DELETED};
                                res_next.status = lphs_pkg::STAT_DELETED;
                            end
                        end
                        default:
                        begin
                            // search, and the unused code behaves as search
                            if (is_match)
                            begin
                                res_next.status = lphs_pkg::STAT_FOUND;
                            end
                        end
                    endcase
                    if ((res_next.status == lphs_pkg::STAT_NOT_FOUND) ||
                        (res_next.status == lphs_pkg::STAT_FULL))
                    begin
                        res_wide = '0;
                    end
                    else
                    begin
                        res_wide = PAD_W'(res_idx);
                    end
                    res_next.slot = res_wide[lphs_pkg::SLOT_W-1:0];
                end
            end
            lphs_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_next = res_reg;
                    out_valid_next = 1'b1;
                    state_next = lphs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lphs_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lphs_pkg::ST_CLEAR;
            clr_reg <= '0;
            cur_reg <= '0;
            count_reg <= '0;
            free_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            cur_reg <= cur_next;
            count_reg <= count_next;
            free_valid_reg <= free_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        free_reg <= free_next;
        mode_reg <= mode_next;
        key_reg <= key_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp = out_reg;

endmodule
